// ===== src/idsp_pkg.sv =====
// Package for the IPTC dataset stream parser: parse phases, result kinds,
// the result record and the push group between parser and result queue.
// No dependencies.
package idsp_pkg;

    // Width of the buffer length and byte position counters (16 to 32)
    localparam int LENGTH_BITS = 32;

    // Result queue depth, a power of two of at least 2
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Marker and size field constants
    localparam logic [7:0]  MARKER   = 8'h1C;
    localparam logic [15:0] SOS_MASK = 16'h7FFF;
    localparam logic [14:0] MAX_SOS  = 15'd4;

    typedef enum logic [2:0] {
        PH_SCAN    = 3'd0,
        PH_RECORD  = 3'd1,
        PH_DATASET = 3'd2,
        PH_SIZE_HI = 3'd3,
        PH_SIZE_LO = 3'd4,
        PH_EXT     = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HDR_OK      = 3'd0,
        KIND_PAYLOAD     = 3'd1,
        KIND_HDR_BADSIZE = 3'd2,
        KIND_SOS_TOOLONG = 3'd3,
        KIND_BUF_END     = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  record;
        logic [7:0]  dataset;
        logic [31:0] payload_size;
        logic [7:0]  payload_byte;
        logic        last_of_run;
    } result_t;

    // Zero or up to two results written in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } res_push_t;

endpackage

// ===== src/idsp_res_fifo.sv =====
// Result queue of the IPTC dataset stream parser: takes up to two results
// a cycle and hands out one a cycle on the result channel while result_stall is low.
// Depends on idsp_pkg.
module idsp_res_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  idsp_pkg::res_push_t push,
    output logic                full_for_two,
    output logic                result_valid,
    input  logic                result_stall,
    output idsp_pkg::result_t   head
);
    import idsp_pkg::*;

    result_t                mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic [RES_PTR_W-1:0]   wr_ptr_plus1;
    logic                   pop;

    assign result_valid = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // Stall input unless two free entries remain
    assign full_for_two = (count_reg > RES_CNT_W'(RES_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push.count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.slot1;
        end
    end

endmodule

// ===== src/iptc_dataset_stream_parser.sv =====
// Top level of the IPTC dataset stream parser: byte-wide parse state
// machine feeding a small result queue.
// Depends on idsp_pkg and idsp_res_fifo.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  item     | item_valid / item_stall   | data_byte, first_of_buffer, total_length
//  result   | result_valid/result_stall | kind, record, dataset, payload_size,
//           |                           | payload_byte, last_of_run
//
// One byte is taken per cycle while item_stall is low; its zero, one or two
// results go to a four-entry queue in that same cycle and leave at one per
// cycle while result_stall is low. A byte with two results (the last byte
// of a buffer) can leave the queue behind, so item_stall rises while fewer
// than two entries are free. rst_n clears parse state and queue asynchronously.
module iptc_dataset_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_of_buffer,
    input  logic [31:0] total_length,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  kind,
    output logic [7:0]  record,
    output logic [7:0]  dataset,
    output logic [31:0] payload_size,
    output logic [7:0]  payload_byte,
    output logic        last_of_run
);
    import idsp_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] position_reg, position_next;
    logic [LENGTH_BITS-1:0] buffer_length_reg, buffer_length_next;
    logic [7:0]             record_reg, record_next;
    logic [7:0]             dataset_reg, dataset_next;
    logic [7:0]             size_first_byte_reg, size_first_byte_next;
    logic [31:0]            size_accumulator_reg, size_accumulator_next;
    logic [2:0]             size_bytes_left_reg, size_bytes_left_next;
    logic [31:0]            payload_left_reg, payload_left_next;

    logic                   accept;
    logic                   full_for_two;
    res_push_t              push;
    result_t                head;

    // Working values after an optional buffer restart
    phase_t                 ph;
    logic [LENGTH_BITS-1:0] pos;
    logic [LENGTH_BITS-1:0] blen;
    logic [LENGTH_BITS-1:0] remaining;
    logic [LENGTH_BITS:0]   pos_plus3;
    logic [15:0]            size_word;
    logic [14:0]            sos;
    logic                   hdr_done;
    logic [31:0]            hdr_size;
    logic                   last;
    logic                   first_v;
    logic                   end_v;
    result_t                first_res;
    result_t                end_res;

    assign accept     = item_valid && !full_for_two;
    assign item_stall = full_for_two;

    // Parse step for one byte
    always_comb
    begin
        ph   = first_of_buffer ? PH_SCAN : phase_reg;
        pos  = first_of_buffer ? '0 : position_reg;
        blen = first_of_buffer ? total_length[LENGTH_BITS-1:0] : buffer_length_reg;

        phase_next            = ph;
        position_next         = pos;
        buffer_length_next    = blen;
        record_next           = first_of_buffer ? 8'd0 : record_reg;
        dataset_next          = first_of_buffer ? 8'd0 : dataset_reg;
        size_first_byte_next  = first_of_buffer ? 8'd0 : size_first_byte_reg;
        size_accumulator_next = first_of_buffer ? 32'd0 : size_accumulator_reg;
        size_bytes_left_next  = first_of_buffer ? 3'd0 : size_bytes_left_reg;
        payload_left_next     = first_of_buffer ? 32'd0 : payload_left_reg;

        remaining = blen - pos - LENGTH_BITS'(1);
        pos_plus3 = (LENGTH_BITS+1)'(pos) + (LENGTH_BITS+1)'(3);
        size_word = {size_first_byte_next, data_byte};
        sos       = size_word[14:0] & SOS_MASK[14:0];
        hdr_done  = 1'b0;
        hdr_size  = 32'd0;
        last      = (payload_left_next <= 32'd1);

        first_v   = 1'b0;
        end_v     = 1'b0;
        first_res = '0;
        end_res   = '0;
        end_res.kind = KIND_BUF_END;

        if (pos < blen)
        begin
            case (ph)
                PH_SCAN:
                begin
                    if (pos_plus3 >= (LENGTH_BITS+1)'(blen))
                        phase_next = PH_DONE;
                    else if (data_byte == MARKER)
                        phase_next = PH_RECORD;
                end
                PH_RECORD:
                begin
                    record_next = data_byte;
                    phase_next  = PH_DATASET;
                end
                PH_DATASET:
                begin
                    dataset_next = data_byte;
                    phase_next   = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    size_first_byte_next = data_byte;
                    phase_next           = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    if (size_first_byte_next[7])
                    begin
                        // Extended size: low 15 bits give the size-of-size
                        if (sos > MAX_SOS)
                        begin
                            first_v           = 1'b1;
                            first_res.kind    = KIND_SOS_TOOLONG;
                            first_res.record  = record_next;
                            first_res.dataset = dataset_next;
                            phase_next        = PH_DONE;
                        end
                        else
                        begin
                            size_accumulator_next = 32'd0;
                            size_bytes_left_next  = sos[2:0];
                            if (sos == 15'd0)
                                hdr_done = 1'b1;
                            else
                                phase_next = PH_EXT;
                        end
                    end
                    else
                    begin
                        size_accumulator_next = 32'(size_word);
                        hdr_size              = 32'(size_word);
                        hdr_done              = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    size_accumulator_next = {size_accumulator_next[23:0], data_byte};
                    size_bytes_left_next  = size_bytes_left_next - 3'd1;
                    hdr_size              = size_accumulator_next;
                    if (size_bytes_left_next == 3'd0)
                        hdr_done = 1'b1;
                end
                PH_PAYLOAD:
                begin
                    first_v                = 1'b1;
                    first_res.kind         = KIND_PAYLOAD;
                    first_res.record       = record_next;
                    first_res.dataset      = dataset_next;
                    first_res.payload_size = size_accumulator_next;
                    first_res.payload_byte = data_byte;
                    first_res.last_of_run  = last;
                    payload_left_next      = last ? 32'd0 : payload_left_next - 32'd1;
                    if (last)
                        phase_next = PH_SCAN;
                end
                default:
                begin
                end
            endcase

            // Header complete: check that the payload fits the buffer
            if (hdr_done)
            begin
                first_v                = 1'b1;
                first_res.record       = record_next;
                first_res.dataset      = dataset_next;
                first_res.payload_size = hdr_size;
                if (hdr_size <= 32'(remaining))
                begin
                    first_res.kind = KIND_HDR_OK;
                    if (hdr_size == 32'd0)
                        phase_next = PH_SCAN;
                    else
                    begin
                        payload_left_next = hdr_size;
                        phase_next        = PH_PAYLOAD;
                    end
                end
                else
                begin
                    first_res.kind = KIND_HDR_BADSIZE;
                    phase_next     = PH_DONE;
                end
            end

            // Advance position, report the end of the buffer
            position_next = pos + LENGTH_BITS'(1);
            if (position_next == blen)
            begin
                end_v      = 1'b1;
                phase_next = PH_DONE;
            end
        end

        // Pack results into the queue write
        push.count = accept ? (2'(first_v) + 2'(end_v)) : 2'd0;
        push.slot0 = first_v ? first_res : end_res;
        push.slot1 = end_res;
    end

    // Parse state registers, updated on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_SCAN;
            position_reg         <= '0;
            buffer_length_reg    <= '0;
            record_reg           <= '0;
            dataset_reg          <= '0;
            size_first_byte_reg  <= '0;
            size_accumulator_reg <= '0;
            size_bytes_left_reg  <= '0;
            payload_left_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg            <= phase_next;
            position_reg         <= position_next;
            buffer_length_reg    <= buffer_length_next;
            record_reg           <= record_next;
            dataset_reg          <= dataset_next;
            size_first_byte_reg  <= size_first_byte_next;
            size_accumulator_reg <= size_accumulator_next;
            size_bytes_left_reg  <= size_bytes_left_next;
            payload_left_reg     <= payload_left_next;
        end
    end

    // Result queue
    idsp_res_fifo u_res_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full_for_two (full_for_two),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign kind         = head.kind;
    assign record       = head.record;
    assign dataset      = head.dataset;
    assign payload_size = head.payload_size;
    assign payload_byte = head.payload_byte;
    assign last_of_run  = head.last_of_run;

endmodule
